FILE: src/bms_pkg.sv
// bms_pkg: shared types, constants and controller states of the box merge sorter
`default_nettype none
package bms_pkg;

  localparam int MAX_BOXES    = 32;
  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;

  localparam int X_W   = 10;
  localparam int Y_W   = 9;
  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  // first member in the high bits: packs as left, top, width, height from bit 0 up
  typedef struct packed {
    logic [Y_W-1:0] height;
    logic [X_W-1:0] width;
    logic [Y_W-1:0] top;
    logic [X_W-1:0] left;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic merge_ok;
    box_t united;
  } merge_res_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MI_RD,
    ST_MI_WT,
    ST_MJ_RD,
    ST_MJ_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_SO_I,
    ST_SO_T,
    ST_SO_RD,
    ST_SO_CMP,
    ST_EM_RD,
    ST_EM_WT
  } state_t;

endpackage
`default_nettype wire

FILE: src/box_merge_sort.sv
// box_merge_sort: box store with greedy pair merge, stable sort by left edge and readout
//
// channel  | dir | tdata (low bit up)                  | tlast        | tuser
// ---------+-----+-------------------------------------+--------------+-----------
// in_      | in  | left[9:0] top[8:0] width[9:0] hgt   | is_final     | -
// out_     | out | left[9:0] top[8:0] width[9:0] hgt   | end_of_list  | overflowed
//
// loading takes one cycle per box, boxes are written straight into the store ram
// the merge pass is data dependent: ST_MI_RD, ST_MI_WT fetch box i, ST_MJ_RD, ST_MJ_CMP
// test each pair, and after a merge ST_SH_RD, ST_SH_WR move each entry down to close
// the gap (one ram read port); the insertion sort picks up a box in ST_SO_I, ST_SO_T and
// compares in ST_SO_RD, ST_SO_CMP; readout goes through ST_EM_RD, ST_EM_WT per result; a
// waiting result holds the readout; the next set can be loaded while the last waits
// reset clears the controller, box count and drop flag; the ram is not cleared
`default_nettype none
module box_merge_sort import bms_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // left, top, width, height, zero pad
  input  wire logic        in_tlast,   // is_final
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // left, top, width, height, zero pad
  output logic             out_tlast,  // end_of_list
  output logic             out_tuser   // overflowed
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;     // boxes in the store
  logic             drop_r, drop_nxt;   // a box was dropped in this set
  logic [CNT_W-1:0] i_r, i_nxt;         // outer index: merge i, sort i, readout
  logic [CNT_W-1:0] j_r, j_nxt;         // merge partner index
  logic [CNT_W-1:0] k_r, k_nxt;         // shift and insertion position
  box_t             cur_r, cur_nxt;     // box i while merging, picked box while sorting

  logic             ov_r, ov_nxt;
  box_t             obox_r, obox_nxt;
  logic             olast_r, olast_nxt;
  logic             oflag_r, oflag_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  box_t             wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  box_t             rd_data;

  logic [CNT_W-1:0] kp1;
  logic [CNT_W-1:0] km1;
  logic [CNT_W-1:0] ip1;
  logic             out_free;
  merge_res_t       mres;

  bms_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bms_merge_unit u_merge (
    .box_a (cur_r),
    .box_b (rd_data),
    .res   (mres)
  );

  assign kp1      = k_r + CNT_W'(1);
  assign km1      = k_r - CNT_W'(1);
  assign ip1      = i_r + CNT_W'(1);
  assign out_free = !ov_r || out_tready;

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, obox_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oflag_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_MI_RD;
        end
      end
      ST_MI_RD:  state_nxt = (i_r >= cnt_r) ? ST_SO_I : ST_MI_WT;
      ST_MI_WT:  state_nxt = ST_MJ_RD;
      ST_MJ_RD:  state_nxt = (j_r >= cnt_r) ? ST_MI_RD : ST_MJ_CMP;
      ST_MJ_CMP: state_nxt = mres.merge_ok ? ST_SH_RD : ST_MJ_RD;
      ST_SH_RD:  state_nxt = (kp1 >= cnt_r) ? ST_MJ_RD : ST_SH_WR;
      ST_SH_WR:  state_nxt = ST_SH_RD;
      ST_SO_I:   state_nxt = (i_r >= cnt_r) ? ST_EM_RD : ST_SO_T;
      ST_SO_T:   state_nxt = ST_SO_RD;
      ST_SO_RD:  state_nxt = (k_r == '0) ? ST_SO_I : ST_SO_CMP;
      ST_SO_CMP: state_nxt = (cur_r.left < rd_data.left) ? ST_SO_RD : ST_SO_I;
      ST_EM_RD: begin
        if (i_r >= cnt_r) begin
          state_nxt = ST_LOAD;
        end else if (out_free) begin
          state_nxt = ST_EM_WT;
        end
      end
      ST_EM_WT:  state_nxt = (ip1 == cnt_r) ? ST_LOAD : ST_EM_RD;
      default:   state_nxt = ST_LOAD;
    endcase
  end

  // ram access and datapath
  always_comb begin
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    ov_nxt    = ov_r && !out_tready;
    obox_nxt  = obox_r;
    olast_nxt = olast_r;
    oflag_nxt = oflag_r;
    wr_en     = 1'b0;
    wr_addr   = i_r[IDX_W-1:0];
    wr_data   = cur_r;
    rd_en     = 1'b0;
    rd_addr   = i_r[IDX_W-1:0];

    case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < CNT_W'(MAX_BOXES)) begin
            wr_en   = 1'b1;
            wr_addr = cnt_r[IDX_W-1:0];
            wr_data = in_tdata[BOX_W-1:0];
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          i_nxt = '0;
        end
      end
      ST_MI_RD: begin
        if (i_r >= cnt_r) begin
          i_nxt = CNT_W'(1);
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_MI_WT: begin
        cur_nxt = rd_data;
        j_nxt   = ip1;
      end
      ST_MJ_RD: begin
        if (j_r >= cnt_r) begin
          i_nxt = ip1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_r[IDX_W-1:0];
        end
      end
      ST_MJ_CMP: begin
        if (mres.merge_ok) begin
          // union replaces box i, then entries above j move down by one
          cur_nxt = mres.united;
          wr_en   = 1'b1;
          wr_data = mres.united;
          k_nxt   = j_r;
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
      end
      ST_SH_RD: begin
        if (kp1 >= cnt_r) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          j_nxt   = ip1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = kp1[IDX_W-1:0];
        end
      end
      ST_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = k_r[IDX_W-1:0];
        wr_data = rd_data;
        k_nxt   = kp1;
      end
      ST_SO_I: begin
        if (i_r >= cnt_r) begin
          i_nxt = '0;
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_SO_T: begin
        cur_nxt = rd_data;
        k_nxt   = i_r;
      end
      ST_SO_RD: begin
        if (k_r == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          i_nxt   = ip1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = km1[IDX_W-1:0];
        end
      end
      ST_SO_CMP: begin
        // strict compare keeps equal left edges in arrival order
        wr_en   = 1'b1;
        wr_addr = k_r[IDX_W-1:0];
        if (cur_r.left < rd_data.left) begin
          wr_data = rd_data;
          k_nxt   = km1;
        end else begin
          i_nxt = ip1;
        end
      end
      ST_EM_RD: begin
        if (i_r >= cnt_r) begin
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
        end else if (out_free) begin
          rd_en = 1'b1;
        end
      end
      ST_EM_WT: begin
        ov_nxt    = 1'b1;
        obox_nxt  = rd_data;
        olast_nxt = (ip1 == cnt_r);
        oflag_nxt = drop_r;
        if (ip1 == cnt_r) begin
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
        end else begin
          i_nxt = ip1;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obox_r  <= obox_nxt;
    olast_r <= olast_nxt;
    oflag_r <= oflag_nxt;
  end

endmodule
`default_nettype wire

FILE: src/bms_ram.sv
// bms_ram: generic simple dual-port ram with registered read
`default_nettype none
module bms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: src/bms_merge_unit.sv
// bms_merge_unit: pair test and union of two boxes
`default_nettype none
module bms_merge_unit import bms_pkg::*; (
  input  wire box_t   box_a,
  input  wire box_t   box_b,
  output merge_res_t res
);

  logic [Y_W-1:0]   h_diff;
  logic [Y_W-1:0]   t_diff;
  logic [X_W:0]     a_right;
  logic [X_W:0]     b_right;
  logic [Y_W:0]     a_bottom;
  logic [Y_W:0]     b_bottom;
  logic [X_W:0]     gap_abs;
  logic [X_W:0]     w_sum;
  logic [X_W+2:0]   gap_x4;
  logic [X_W+2:0]   w_sum_x3;
  logic             h_ok;
  logic             t_ok;
  logic             g_ok;
  logic [X_W:0]     right;
  logic [Y_W:0]     bottom;
  logic [X_W-1:0]   u_left;
  logic [Y_W-1:0]   u_top;
  logic [X_W:0]     u_w;
  logic [Y_W:0]     u_h;

  always_comb begin
    h_diff = (box_a.height >= box_b.height) ? box_a.height - box_b.height
                                            : box_b.height - box_a.height;
    t_diff = (box_a.top >= box_b.top) ? box_a.top - box_b.top
                                      : box_b.top - box_a.top;
    h_ok = {h_diff, 1'b0} < {1'b0, box_a.height};
    t_ok = {t_diff, 1'b0} < {1'b0, box_a.height};

    a_right  = {1'b0, box_a.left} + {1'b0, box_a.width};
    b_right  = {1'b0, box_b.left} + {1'b0, box_b.width};
    a_bottom = {1'b0, box_a.top} + {1'b0, box_a.height};
    b_bottom = {1'b0, box_b.top} + {1'b0, box_b.height};

    // distance between near edges, taken by magnitude
    if (box_a.left < box_b.left) begin
      gap_abs = ({1'b0, box_b.left} >= a_right) ? {1'b0, box_b.left} - a_right
                                                : a_right - {1'b0, box_b.left};
    end else begin
      gap_abs = ({1'b0, box_a.left} >= b_right) ? {1'b0, box_a.left} - b_right
                                                : b_right - {1'b0, box_a.left};
    end
    w_sum    = {1'b0, box_a.width} + {1'b0, box_b.width};
    gap_x4   = {gap_abs, 2'b00};
    w_sum_x3 = {2'b00, w_sum} + {1'b0, w_sum, 1'b0};
    g_ok     = gap_x4 < w_sum_x3;

    right  = (a_right >= b_right) ? a_right : b_right;
    bottom = (a_bottom >= b_bottom) ? a_bottom : b_bottom;
    u_left = (box_a.left <= box_b.left) ? box_a.left : box_b.left;
    u_top  = (box_a.top <= box_b.top) ? box_a.top : box_b.top;
    u_w    = right - {1'b0, u_left};
    u_h    = bottom - {1'b0, u_top};
    if (u_w > (X_W+1)'(IMAGE_WIDTH)) begin
      u_w = (X_W+1)'(IMAGE_WIDTH);
    end
    if (u_h > (Y_W+1)'(IMAGE_HEIGHT)) begin
      u_h = (Y_W+1)'(IMAGE_HEIGHT);
    end

    res.merge_ok      = h_ok && t_ok && g_ok;
    res.united.left   = u_left;
    res.united.top    = u_top;
    res.united.width  = u_w[X_W-1:0];
    res.united.height = u_h[Y_W-1:0];
  end

endmodule
`default_nettype wire

FILE: dv/box_merge_sort_tb.sv
// box_merge_sort_tb: self-checking stream testbench for the box merge sorter
`timescale 1ns / 100ps
module box_merge_sort_tb;
  import bms_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_ITEMS = 396;

  typedef enum int {SET_ROW, SET_UNIFORM, SET_NOISE} set_kind_t;

  // one box request waiting to go out on the input channel
  typedef struct {
    box_t b;
    bit   fin;
    bit   drain;       // wait until every result so far has come back
    bit   go_random;   // first request of the random part
  } box_req_t;

  // one surviving box as the block should emit it
  typedef struct {
    box_t b;
    bit   eol;
    bit   ovf;
  } survivor_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  box_req_t  boxes_to_send[$];
  box_req_t  cur_req;
  box_t      set_q[$];        // boxes held for the current set
  bit        set_dropped;
  survivor_t survivors_q[$];  // expected results, oldest first

  int  errors = 0;
  int  cycles = 0;
  int  send_idle = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;
  bit  random_phase = 1'b0;
  bit  long_armed = 1'b1;

  always #6 clk = ~clk;

  box_merge_sort dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  task automatic report_mismatch(string fld, int got, int want);
    errors++;
    if (errors <= 40)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, fld, got, want);
  endtask

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  // the three closeness tests, as exact integer cross products
  function automatic bit joinable(box_t a, box_t b);
    int gap;
    if (2 * iabs(int'(a.height) - int'(b.height)) >= int'(a.height)) return 1'b0;
    if (2 * iabs(int'(a.top) - int'(b.top)) >= int'(a.height)) return 1'b0;
    if (a.left < b.left) gap = int'(b.left) - (int'(a.left) + int'(a.width));
    else gap = int'(a.left) - (int'(b.left) + int'(b.width));
    return 4 * iabs(gap) < 3 * (int'(a.width) + int'(b.width));
  endfunction

  // union of two boxes, size clipped to the image
  function automatic box_t union_of(box_t a, box_t b);
    int   lf, tp, rt, bt, ra, rb, ba, bb;
    box_t m;
    ra = int'(a.left) + int'(a.width);
    rb = int'(b.left) + int'(b.width);
    ba = int'(a.top) + int'(a.height);
    bb = int'(b.top) + int'(b.height);
    lf = (a.left < b.left) ? int'(a.left) : int'(b.left);
    tp = (a.top < b.top) ? int'(a.top) : int'(b.top);
    rt = (ra > rb) ? ra : rb;
    bt = (ba > bb) ? ba : bb;
    m.left   = X_W'(lf);
    m.top    = Y_W'(tp);
    m.width  = X_W'((rt - lf) < IMAGE_WIDTH ? rt - lf : IMAGE_WIDTH);
    m.height = Y_W'((bt - tp) < IMAGE_HEIGHT ? bt - tp : IMAGE_HEIGHT);
    return m;
  endfunction

  // stores one accepted box; on the final one, merges, sorts and queues the survivors
  task automatic merge_and_sort(box_t b, bit fin);
    int        i, j, k;
    box_t      t;
    survivor_t s;
    if (set_q.size() < MAX_BOXES) set_q.insert(set_q.size(), b);
    else set_dropped = 1'b1;
    if (!fin) return;
    // greedy pair merge, scan of i restarts after every merge
    i = 0;
    while (i < set_q.size()) begin
      j = i + 1;
      while (j < set_q.size()) begin
        if (joinable(set_q[i], set_q[j])) begin
          set_q[i] = union_of(set_q[i], set_q[j]);
          set_q.delete(j);
          j = i + 1;
        end else begin
          j++;
        end
      end
      i++;
    end
    // stable insertion sort on the left edge
    for (i = 1; i < set_q.size(); i++) begin
      t = set_q[i];
      k = i;
      while (k > 0 && t.left < set_q[k-1].left) begin
        set_q[k] = set_q[k-1];
        k--;
      end
      set_q[k] = t;
    end
    foreach (set_q[n]) begin
      s.b   = set_q[n];
      s.eol = (n == set_q.size() - 1);
      s.ovf = set_dropped;
      survivors_q.insert(survivors_q.size(), s);
    end
    set_q.delete();
    set_dropped = 1'b0;
  endtask

  task automatic check_result();
    survivor_t w;
    box_t      got;
    got = out_tdata[BOX_W-1:0];
    if (survivors_q.size() == 0) begin
      report_mismatch("result with nothing expected", int'(got.left), 0);
      return;
    end
    w = survivors_q.pop_front();
    if (got.left != w.b.left) report_mismatch("left", got.left, w.b.left);
    if (got.top != w.b.top) report_mismatch("top", got.top, w.b.top);
    if (got.width != w.b.width) report_mismatch("width", got.width, w.b.width);
    if (got.height != w.b.height) report_mismatch("height", got.height, w.b.height);
    if (out_tlast != w.eol) report_mismatch("end_of_list", out_tlast, w.eol);
    if (out_tuser != w.ovf) report_mismatch("overflowed", out_tuser, w.ovf);
    if (out_tdata[39:BOX_W] != '0) report_mismatch("tdata pad", out_tdata[39:BOX_W], 0);
  endtask

  task automatic add_box(int l, int t, int w, int h, bit fin);
    box_req_t r;
    r.b.left   = X_W'(l);
    r.b.top    = Y_W'(t);
    r.b.width  = X_W'(w);
    r.b.height = Y_W'(h);
    r.fin = fin;
    r.drain = 1'b0;
    r.go_random = 1'b0;
    boxes_to_send.insert(boxes_to_send.size(), r);
  endtask

  // one whole set of n boxes, the last marked final
  task automatic add_set(set_kind_t kind, int n, bit drain);
    box_t     grp[$];
    box_t     bx, sw;
    box_req_t r;
    int       x, top0, h0, w, a, c;
    top0 = $urandom_range(0, 430);
    h0   = $urandom_range(6, 80);
    x    = $urandom_range(0, 300);
    for (int k = 0; k < n; k++) begin
      case (kind)
        SET_ROW: begin
          // a row of glyph-like boxes: similar heights and tops, small gaps
          w = $urandom_range(2, 40);
          bx.left   = X_W'(x);
          bx.top    = Y_W'(top0 + $urandom_range(0, h0 / 2));
          bx.width  = X_W'(w);
          bx.height = Y_W'(h0 - h0 / 4 + $urandom_range(0, h0 / 2));
          x = x + w + $urandom_range(0, w) - w / 3;
        end
        SET_UNIFORM: begin
          bx.left   = X_W'($urandom_range(0, 639));
          bx.top    = Y_W'($urandom_range(0, 479));
          bx.width  = X_W'($urandom_range(1, 640));
          bx.height = Y_W'($urandom_range(1, 480));
        end
        default: begin
          // any bit pattern the fields can hold, zero sizes included
          bx.left   = X_W'($urandom());
          bx.top    = Y_W'($urandom());
          bx.width  = X_W'($urandom());
          bx.height = Y_W'($urandom());
        end
      endcase
      grp.insert(grp.size(), bx);
    end
    // shuffle a little so the merge order is not always left to right
    for (int s = 0; s < n / 3; s++) begin
      a = $urandom_range(0, n - 1);
      c = $urandom_range(0, n - 1);
      sw = grp[a];
      grp[a] = grp[c];
      grp[c] = sw;
    end
    foreach (grp[k]) begin
      r.b = grp[k];
      r.fin = (k == n - 1);
      r.drain = drain && (k == 0);
      r.go_random = 1'b0;
      boxes_to_send.insert(boxes_to_send.size(), r);
    end
  endtask

  // driver: one request per handshake, random gaps after accepted requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) merge_and_sort(cur_req.b, cur_req.fin);
      if (!in_tvalid || in_tready) begin
        if (in_tvalid && !calm && $urandom_range(0, 3) == 0)
          send_idle = $urandom_range(1, 4);
        if (send_idle > 0) begin
          send_idle--;
          in_tvalid <= 1'b0;
        end else if (boxes_to_send.size() == 0 ||
                     (boxes_to_send[0].drain && survivors_q.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          cur_req = boxes_to_send.pop_front();
          if (cur_req.go_random) random_phase = 1'b1;
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, cur_req.b};
          in_tlast  <= cur_req.fin;
        end
      end
    end
  end

  // receiver: short random stalls, plus one long hold once the random part runs
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (long_armed && random_phase && out_tvalid) begin
        long_armed = 1'b0;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int       sent, set_no, r, n;
    set_kind_t kind;

    // directed: field extremes
    add_box(0, 0, 1, 1, 1'b1);
    add_box(1023, 511, 1023, 511, 1'b1);
    // union wider than the image, clipped in width
    add_box(0, 0, 640, 480, 1'b0);
    add_box(600, 10, 640, 470, 1'b1);
    // union taller than the image, clipped in height
    add_box(0, 0, 10, 480, 1'b0);
    add_box(0, 100, 10, 480, 1'b1);
    // zero height: the height tests fail
    add_box(12, 10, 20, 0, 1'b0);
    add_box(10, 10, 20, 0, 1'b1);
    // zero width sum: the gap test fails, equal left edges keep their order
    add_box(100, 50, 0, 40, 1'b0);
    add_box(100, 60, 0, 40, 1'b1);
    // far apart, reverse order: pure sort
    add_box(500, 0, 10, 10, 1'b0);
    add_box(300, 200, 10, 10, 1'b0);
    add_box(100, 400, 10, 10, 1'b1);
    // a merge that restarts the inner scan
    add_box(0, 100, 20, 40, 1'b0);
    add_box(100, 100, 20, 40, 1'b0);
    add_box(25, 100, 20, 40, 1'b0);
    add_box(48, 102, 30, 38, 1'b1);

    // random sets, mostly rows of nearby boxes that tend to merge
    sent = 0;
    set_no = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      kind = (r < 55) ? SET_ROW : (r < 78) ? SET_UNIFORM : SET_NOISE;
      n = $urandom_range(1, 10);
      if (set_no == 4) begin
        kind = SET_ROW;
        n = 33;              // final box itself is dropped
      end else if (set_no == 12) begin
        kind = SET_UNIFORM;
        n = 40;
      end else if (set_no == 20) begin
        kind = SET_NOISE;
        n = 34;
      end else if ($urandom_range(0, 15) == 0) begin
        kind = SET_ROW;
        n = MAX_BOXES;
      end
      if (set_no == 0) begin
        add_set(kind, n, 1'b1);
        boxes_to_send[boxes_to_send.size() - n].go_random = 1'b1;
      end else begin
        add_set(kind, n, set_no % 12 == 0);
      end
      sent += n;
      set_no++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // no idling in the last stretch
    while (boxes_to_send.size() >= 60) @(posedge clk);
    calm = 1'b1;
    while (boxes_to_send.size() != 0 || in_tvalid) @(posedge clk);
    while (survivors_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
